// ----- rtl/ghal_pkg.sv -----
// Shared types, command and status codes for the generational handle allocator.
package ghal_pkg;

   // Default slot count
   localparam int NUM_SLOTS_DEF = 64;

   // Handle layout: generation in the upper half, slot index plus one in the lower half
   localparam int HANDLE_W = 64;
   localparam int GEN_W    = 32;

   // Generation given to a slot on first use and after a wrap
   localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;

   // Command codes
   localparam logic [1:0] CMD_ALLOC    = 2'd0;
   localparam logic [1:0] CMD_FREE     = 2'd1;
   localparam logic [1:0] CMD_VALIDATE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // Request word
   typedef struct packed {
      logic [1:0]          cmd;
      logic [HANDLE_W-1:0] handle_in;
   } req_type;

   // Response word
   typedef struct packed {
      logic [HANDLE_W-1:0] handle_out;
      logic [1:0]          status;
   } rsp_type;

   // Pipeline control from the handshake logic to the engine
   typedef struct packed {
      logic accept;   // request word taken into the stage register
      logic fire;     // stage register word processed into the response register
   } ctl_type;

endpackage

// ----- rtl/ghal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ghal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read (read returns the old word on a collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ghal_engine.sv -----
// Allocator engine: generation table, free stack, counters and per-command decision logic.
module ghal_engine #(
   parameter int NUM_SLOTS = ghal_pkg::NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ghal_pkg::ctl_type ctl,
   input  ghal_pkg::req_type req_word,   // word being accepted this cycle
   input  ghal_pkg::req_type s1_word,    // word held in the stage register
   output ghal_pkg::rsp_type result
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam int GEN_W = ghal_pkg::GEN_W;
   localparam int LOW_W = ghal_pkg::HANDLE_W - ghal_pkg::GEN_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_SLOTS);

   // Counters
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] slots_in_use_ff, slots_in_use_in;
   logic [CNT_W-1:0] fc_less1, fc_less2;

   // Collision bypass registers
   logic             gen_hit_ff, gen_hit_in;
   logic [GEN_W-1:0] gen_hit_data_ff, gen_hit_data_in;
   logic             stk_hit1_ff, stk_hit1_in;
   logic             stk_hit2_ff, stk_hit2_in;
   logic [IDX_W-1:0] stk_hit_data_ff, stk_hit_data_in;

   // Memory ports
   logic             gen_we;
   logic [IDX_W-1:0] gen_waddr, gen_raddr;
   logic [GEN_W-1:0] gen_wdata, gen_rd_data;
   logic             stk_we;
   logic [IDX_W-1:0] stk_waddr, stk_wdata;
   logic [IDX_W-1:0] stk_raddr1, stk_raddr2, stk_rd1, stk_rd2;

   // Decode of the staged word
   logic [LOW_W-1:0] s1_low, cnt_low;
   logic [GEN_W-1:0] s1_gen, gen_cur, gen_next;
   logic [IDX_W-1:0] s1_idx, top_idx, second_idx, new_top_idx, fresh_idx;
   logic             handle_ok, push_now, pop_now;

   // Generation table
   ghal_ram #(
      .WIDTH (GEN_W),
      .DEPTH (NUM_SLOTS)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_we),
      .wr_addr (gen_waddr),
      .wr_data (gen_wdata),
      .rd_en   (ctl.accept),
      .rd_addr (gen_raddr),
      .rd_data (gen_rd_data)
   );

   // Free stack, two copies so the top and the entry below it read together
   ghal_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_SLOTS)
   ) u_stk_ram_top (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (1'b1),
      .rd_addr (stk_raddr1),
      .rd_data (stk_rd1)
   );

   ghal_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_SLOTS)
   ) u_stk_ram_next (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (1'b1),
      .rd_addr (stk_raddr2),
      .rd_data (stk_rd2)
   );

   // Field split and handle check
   always_comb begin
      s1_low     = s1_word.handle_in[LOW_W-1:0];
      s1_gen     = s1_word.handle_in[ghal_pkg::HANDLE_W-1:LOW_W];
      s1_idx     = IDX_W'(s1_low - LOW_W'(1));
      cnt_low    = LOW_W'(slots_in_use_ff);
      fresh_idx  = slots_in_use_ff[IDX_W-1:0];
      gen_cur    = gen_hit_ff  ? gen_hit_data_ff : gen_rd_data;
      top_idx    = stk_hit1_ff ? stk_hit_data_ff : stk_rd1;
      second_idx = stk_hit2_ff ? stk_hit_data_ff : stk_rd2;
      handle_ok  = (s1_low != '0) && (s1_gen != '0) && (s1_low <= cnt_low) &&
                   (gen_cur == s1_gen);
      // generation bump skips zero on wrap
      gen_next   = (gen_cur == '1) ? ghal_pkg::GEN_FIRST : gen_cur + GEN_W'(1);
   end

   // Command execution
   always_comb begin
      free_count_in     = free_count_ff;
      slots_in_use_in   = slots_in_use_ff;
      gen_we            = 1'b0;
      gen_waddr         = s1_idx;
      gen_wdata         = gen_next;
      push_now          = 1'b0;
      pop_now           = 1'b0;
      result.handle_out = '0;
      result.status     = ghal_pkg::ST_INVALID;
      if (ctl.fire) begin
         case (s1_word.cmd)
            ghal_pkg::CMD_ALLOC: begin
               if (free_count_ff != '0) begin
                  // reuse the most recently freed slot
                  pop_now           = 1'b1;
                  free_count_in     = free_count_ff - CNT_W'(1);
                  result.handle_out = {gen_cur, LOW_W'(top_idx) + LOW_W'(1)};
                  result.status     = ghal_pkg::ST_OK;
               end else if (slots_in_use_ff != CNT_FULL) begin
                  // fresh slot: seed its generation
                  slots_in_use_in   = slots_in_use_ff + CNT_W'(1);
                  gen_we            = 1'b1;
                  gen_waddr         = fresh_idx;
                  gen_wdata         = ghal_pkg::GEN_FIRST;
                  result.handle_out = {ghal_pkg::GEN_FIRST, cnt_low + LOW_W'(1)};
                  result.status     = ghal_pkg::ST_OK;
               end else begin
                  result.status     = ghal_pkg::ST_FULL;
               end
            end
            ghal_pkg::CMD_FREE: begin
               if (handle_ok && (free_count_ff != CNT_FULL)) begin
                  push_now      = 1'b1;
                  free_count_in = free_count_ff + CNT_W'(1);
                  gen_we        = 1'b1;
                  result.status = ghal_pkg::ST_OK;
               end
            end
            ghal_pkg::CMD_VALIDATE: begin
               if (handle_ok) begin
                  result.status = ghal_pkg::ST_OK;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Stack write and read addresses for the next cycle
   always_comb begin
      stk_we      = push_now;
      stk_waddr   = free_count_ff[IDX_W-1:0];
      stk_wdata   = s1_idx;
      fc_less1    = free_count_in - CNT_W'(1);
      fc_less2    = free_count_in - CNT_W'(2);
      stk_raddr1  = fc_less1[IDX_W-1:0];
      stk_raddr2  = fc_less2[IDX_W-1:0];
      // top of stack as it stands after this cycle's command
      new_top_idx = pop_now ? second_idx : (push_now ? s1_idx : top_idx);
      if (req_word.cmd == ghal_pkg::CMD_ALLOC) begin
         gen_raddr = new_top_idx;
      end else begin
         gen_raddr = IDX_W'(req_word.handle_in[LOW_W-1:0] - LOW_W'(1));
      end
   end

   // Bypass for reads that collide with this cycle's writes
   always_comb begin
      gen_hit_in      = gen_hit_ff;
      gen_hit_data_in = gen_hit_data_ff;
      if (ctl.accept) begin
         gen_hit_in      = gen_we && (gen_waddr == gen_raddr);
         gen_hit_data_in = gen_wdata;
      end
      stk_hit1_in     = stk_we && (stk_waddr == stk_raddr1);
      stk_hit2_in     = stk_we && (stk_waddr == stk_raddr2);
      stk_hit_data_in = stk_wdata;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff   <= '0;
         slots_in_use_ff <= '0;
         gen_hit_ff      <= 1'b0;
         stk_hit1_ff     <= 1'b0;
         stk_hit2_ff     <= 1'b0;
      end else begin
         free_count_ff   <= free_count_in;
         slots_in_use_ff <= slots_in_use_in;
         gen_hit_ff      <= gen_hit_in;
         stk_hit1_ff     <= stk_hit1_in;
         stk_hit2_ff     <= stk_hit2_in;
      end
   end

   // Bypass data
   always_ff @(posedge clock) begin
      gen_hit_data_ff <= gen_hit_data_in;
      stk_hit_data_ff <= stk_hit_data_in;
   end

   // Counters stay within the slot count
   assert property (@(posedge clock) disable iff (reset)
      (free_count_ff <= CNT_FULL) && (slots_in_use_ff <= CNT_FULL))
      else $error("allocator counter beyond slot count");

   // A fresh allocation raises the high-water mark by one
   assert property (@(posedge clock) disable iff (reset)
      ctl.fire && (s1_word.cmd == ghal_pkg::CMD_ALLOC) && (free_count_ff == '0) &&
      (slots_in_use_ff != CNT_FULL)
      |=> (slots_in_use_ff == $past(slots_in_use_ff) + 1))
      else $error("fresh allocation did not advance slots in use");

   // A reuse allocation pops exactly one stack entry and leaves the mark alone
   assert property (@(posedge clock) disable iff (reset)
      ctl.fire && (s1_word.cmd == ghal_pkg::CMD_ALLOC) && (free_count_ff != '0)
      |=> (free_count_ff == $past(free_count_ff) - 1) &&
          (slots_in_use_ff == $past(slots_in_use_ff)))
      else $error("stack pop bookkeeping wrong");

endmodule

// ----- rtl/generational_handle_allocator_top.sv -----
// Top level of the generational handle allocator: handshake, stage and response registers.
//
// Hands out 64-bit handles for NUM_SLOTS slots: generation in bits 63..32, slot index
// plus one in bits 31..0. Allocate reuses the most recently freed slot first, then
// fresh slots, and answers status 2 when none is left; free and validate answer
// status 1 for a zero, out-of-range or stale handle. Every command yields exactly one
// response word. One command is taken per clock cycle, with no bubbles between any
// mix of commands while the response side keeps up. A response word passes through the
// stage register, then the response register, after its request is accepted, and a
// stall on the response side can hold it in either. The generation table is a RAM with
// a registered read, addressed in the cycle a request is accepted; the free stack is a
// pair of such RAMs with reads always enabled. Every command is finished in one pass
// through the stage that follows. No clearing pass is needed after reset: a slot's
// generation is written when it is first used.
module generational_handle_allocator_top #(
   parameter int NUM_SLOTS = ghal_pkg::NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ghal_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ghal_pkg::rsp_type rsp_word
);

   logic              s1_valid_ff, s1_valid_in;
   ghal_pkg::req_type s1_word_ff, s1_word_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ghal_pkg::rsp_type rsp_word_ff, rsp_word_in;
   ghal_pkg::rsp_type eng_result;
   ghal_pkg::ctl_type ctl;
   logic              out_open;

   // Handshake: the stage advances whenever the response register can take a word
   always_comb begin
      out_open   = !rsp_valid_ff || !rsp_stall;
      ctl.fire   = s1_valid_ff && out_open;
      req_stall  = s1_valid_ff && !out_open;
      ctl.accept = req_valid && !req_stall;
   end

   ghal_engine #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_word (req_word),
      .s1_word  (s1_word_ff),
      .result   (eng_result)
   );

   // Next values of stage and response registers
   always_comb begin
      s1_valid_in  = ctl.accept || (s1_valid_ff && !ctl.fire);
      s1_word_in   = ctl.accept ? req_word : s1_word_ff;
      rsp_valid_in = ctl.fire || (rsp_valid_ff && rsp_stall);
      rsp_word_in  = ctl.fire ? eng_result : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Only a successful command carries a handle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.status != ghal_pkg::ST_OK)
      |-> (rsp_word_ff.handle_out == '0))
      else $error("failed command returned a handle");

   // A queued response is not lost when a new request enters behind it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("stalled response word changed");

   // A word waiting in the stage register stays put
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !ctl.fire |=> s1_valid_ff && $stable(s1_word_ff))
      else $error("stalled stage word changed");

endmodule

// ----- tb/generational_handle_allocator_top_tb.sv -----
// Self-checking testbench for the generational handle allocator top level.
`timescale 1ns / 100ps

module generational_handle_allocator_top_tb;

   localparam int NUM_SLOTS = ghal_pkg::NUM_SLOTS_DEF;
   localparam int RANDOM_ITEMS = 420;
   localparam int QUIET_LIMIT = 500;
   // cmd 3 is unused by the block but still answers
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ghal_pkg::req_type req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ghal_pkg::rsp_type rsp_word;

   generational_handle_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the allocator state
   logic [ghal_pkg::GEN_W-1:0] slot_gen [NUM_SLOTS];
   int unsigned                recycle_stack [NUM_SLOTS];
   int unsigned                recycle_depth;
   int unsigned                slots_taken;

   ghal_pkg::req_type commands_waiting [$];
   ghal_pkg::rsp_type answers_due [$];
   ghal_pkg::rsp_type answer_head;
   int                fails = 0;
   int                idle_odds = 0;   // chance out of 16 of starting an idle burst
   int                send_gap = 0;
   int                hold_left = 0;
   int                quiet_cycles = 0;

   // Handle check: nonzero halves, slot already taken, generation current
   function automatic bit handle_live(input logic [ghal_pkg::HANDLE_W-1:0] h,
                                      output int unsigned slot);
      logic [31:0]                low;
      logic [ghal_pkg::GEN_W-1:0] gen;
      low  = h[31:0];
      gen  = h[63:32];
      slot = 0;
      if (low == 0 || gen == 0) return 1'b0;
      if (low - 32'd1 >= slots_taken) return 1'b0;
      slot = low - 32'd1;
      return slot_gen[slot] == gen;
   endfunction

   // Expected response word for one command; updates the shadow state
   function automatic ghal_pkg::rsp_type allocator_answer(input ghal_pkg::req_type r);
      ghal_pkg::rsp_type          a;
      int unsigned                slot;
      logic [ghal_pkg::GEN_W-1:0] g;
      a.handle_out = '0;
      a.status     = ghal_pkg::ST_INVALID;
      slot         = NUM_SLOTS;
      case (r.cmd)
         ghal_pkg::CMD_ALLOC: begin
            if (recycle_depth > 0) begin
               recycle_depth = recycle_depth - 1;
               slot = recycle_stack[recycle_depth];
            end else if (slots_taken < NUM_SLOTS) begin
               slot = slots_taken;
               slots_taken = slots_taken + 1;
            end
            if (slot < NUM_SLOTS) begin
               a.handle_out = {slot_gen[slot], 32'(slot + 1)};
               a.status     = ghal_pkg::ST_OK;
            end else begin
               a.status = ghal_pkg::ST_FULL;
            end
         end
         ghal_pkg::CMD_FREE: begin
            // a forged handle can pass the check with the stack already full
            if (handle_live(r.handle_in, slot) && recycle_depth < NUM_SLOTS) begin
               g = slot_gen[slot] + 1'b1;
               if (g == 0) g = ghal_pkg::GEN_FIRST;   // generation never wraps to zero
               slot_gen[slot] = g;
               recycle_stack[recycle_depth] = slot;
               recycle_depth = recycle_depth + 1;
               a.status = ghal_pkg::ST_OK;
            end
         end
         ghal_pkg::CMD_VALIDATE: begin
            if (handle_live(r.handle_in, slot)) a.status = ghal_pkg::ST_OK;
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic void queue_cmd(input logic [1:0] cmd,
                                     input logic [ghal_pkg::HANDLE_W-1:0] h);
      ghal_pkg::req_type r;
      r.cmd       = cmd;
      r.handle_in = h;
      commands_waiting = {commands_waiting, r};
   endfunction

   // Handle of a taken slot at its current generation, or a random one while no slot is taken
   function automatic logic [ghal_pkg::HANDLE_W-1:0] live_handle();
      int unsigned s;
      if (slots_taken == 0) return {$urandom, $urandom};
      s = $urandom_range(0, slots_taken - 1);
      return {slot_gen[s], 32'(s + 1)};
   endfunction

   // Malformed, stale or random handles
   function automatic logic [ghal_pkg::HANDLE_W-1:0] odd_handle();
      int unsigned s;
      s = (slots_taken == 0) ? 0 : $urandom_range(0, slots_taken - 1);
      case ($urandom_range(0, 6))
         0: return {$urandom, $urandom};
         1: return '0;
         2: return {32'd0, 32'(s + 1)};
         3: return {slot_gen[s], 32'd0};
         4: return {slot_gen[s], 32'(slots_taken + 1 + $urandom_range(0, 70))};
         5: return {slot_gen[s] + 32'($urandom_range(1, 3)), 32'(s + 1)};
         default: return '1;
      endcase
   endfunction

   // Request side: feeds queued words, predicts each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) answers_due = {answers_due, allocator_answer(req_word)};
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (commands_waiting.size() == 0) begin
               req_valid <= 1'b0;
            end else if ($urandom_range(0, 15) < idle_odds) begin
               req_valid <= 1'b0;
               send_gap  <= $urandom_range(0, 10);
            end else begin
               req_valid <= 1'b1;
               req_word  <= commands_waiting.pop_front();
            end
         end
      end
   end

   // Response side: random stall bursts, compares each accepted word
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("response word with no command outstanding: %h", rsp_word);
               fails++;
            end else begin
               answer_head = answers_due.pop_front();
               if (rsp_word.handle_out !== answer_head.handle_out) begin
                  $error("handle_out: expected %h, actual %h",
                         answer_head.handle_out, rsp_word.handle_out);
                  fails++;
               end
               if (rsp_word.status !== answer_head.status) begin
                  $error("status: expected %0d, actual %0d",
                         answer_head.status, rsp_word.status);
                  fails++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if ($urandom_range(0, 15) < idle_odds) begin
            rsp_stall <= 1'b1;
            hold_left <= $urandom_range(0, 10);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (commands_waiting.size() != 0 || req_valid || answers_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int          issued;
      int          batch;
      int          pick;
      int          alloc_pct;
      int          n;
      int          j;
      int unsigned t;
      int unsigned order [NUM_SLOTS];

      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot_gen[k]      = ghal_pkg::GEN_FIRST;
         recycle_stack[k] = 0;
      end
      recycle_depth = 0;
      slots_taken   = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero and malformed handles, unused command, reuse order
      idle_odds = 3;
      queue_cmd(ghal_pkg::CMD_VALIDATE, '0);
      queue_cmd(ghal_pkg::CMD_FREE, '0);
      queue_cmd(CMD_UNUSED, '1);
      queue_cmd(ghal_pkg::CMD_ALLOC, {$urandom, $urandom});
      queue_cmd(ghal_pkg::CMD_ALLOC, '0);
      queue_cmd(ghal_pkg::CMD_VALIDATE, {32'd1, 32'd1});
      queue_cmd(ghal_pkg::CMD_VALIDATE, {32'd0, 32'd1});
      queue_cmd(ghal_pkg::CMD_VALIDATE, {32'd1, 32'd0});
      queue_cmd(ghal_pkg::CMD_VALIDATE, {32'd1, 32'd3});
      queue_cmd(ghal_pkg::CMD_VALIDATE, {32'd1, 32'hFFFF_FFFF});
      queue_cmd(ghal_pkg::CMD_VALIDATE, {32'd2, 32'd1});
      queue_cmd(ghal_pkg::CMD_FREE, {32'd1, 32'd1});
      queue_cmd(ghal_pkg::CMD_VALIDATE, {32'd1, 32'd1});
      queue_cmd(ghal_pkg::CMD_FREE, {32'd1, 32'd1});
      queue_cmd(ghal_pkg::CMD_VALIDATE, {32'd2, 32'd1});
      queue_cmd(ghal_pkg::CMD_ALLOC, '0);
      queue_cmd(ghal_pkg::CMD_FREE, {32'd1, 32'd2});
      queue_cmd(ghal_pkg::CMD_FREE, {32'd2, 32'd1});
      queue_cmd(ghal_pkg::CMD_ALLOC, '0);
      queue_cmd(ghal_pkg::CMD_ALLOC, '0);
      queue_cmd(ghal_pkg::CMD_ALLOC, '0);
      queue_cmd(ghal_pkg::CMD_VALIDATE, '1);
      queue_cmd(ghal_pkg::CMD_FREE, {32'hFFFF_FFFF, 32'd2});

      // Random batches, each built from the shadow state once the block is drained
      issued = 0;
      batch  = 0;
      while (issued < RANDOM_ITEMS) begin
         wait_drained();
         idle_odds = (issued > RANDOM_ITEMS - 70) ? 0 : $urandom_range(0, 5);
         pick = (batch == 0) ? 0 : (batch == 1) ? 1 : $urandom_range(0, 19);
         if (pick == 0) begin
            // allocate a long run, past the last slot in the first batch
            n = (batch == 0) ? NUM_SLOTS + 4 : $urandom_range(20, 70);
            for (int k = 0; k < n; k++) queue_cmd(ghal_pkg::CMD_ALLOC, {$urandom, $urandom});
         end else if (pick == 1) begin
            // free every taken slot in random order, then overfill the stack
            n = slots_taken + 2;
            for (int k = 0; k < slots_taken; k++) order[k] = k;
            for (int k = slots_taken - 1; k > 0; k--) begin
               j = $urandom_range(0, k);
               t = order[k];
               order[k] = order[j];
               order[j] = t;
            end
            for (int k = 0; k < slots_taken; k++)
               queue_cmd(ghal_pkg::CMD_FREE, {slot_gen[order[k]], 32'(order[k] + 1)});
            queue_cmd(ghal_pkg::CMD_FREE, live_handle());
            queue_cmd(ghal_pkg::CMD_FREE, live_handle());
         end else begin
            // mostly well-formed traffic with some noise
            n = $urandom_range(6, 24);
            alloc_pct = $urandom_range(15, 50);
            for (int k = 0; k < n; k++) begin
               t = $urandom_range(0, 99);
               if (t < alloc_pct) queue_cmd(ghal_pkg::CMD_ALLOC, {$urandom, $urandom});
               else if (t < alloc_pct + 30) queue_cmd(ghal_pkg::CMD_FREE, live_handle());
               else if (t < alloc_pct + 50) queue_cmd(ghal_pkg::CMD_VALIDATE, live_handle());
               else begin
                  case ($urandom_range(0, 2))
                     0: queue_cmd(ghal_pkg::CMD_FREE, odd_handle());
                     1: queue_cmd(ghal_pkg::CMD_VALIDATE, odd_handle());
                     default: queue_cmd(CMD_UNUSED, {$urandom, $urandom});
                  endcase
               end
            end
         end
         issued += n;
         batch++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fails == 0 && answers_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ghal_pkg.sv
rtl/ghal_ram.sv
rtl/ghal_engine.sv
rtl/generational_handle_allocator_top.sv
tb/generational_handle_allocator_top_tb.sv
